[src/opf_pkg.sv]
package opf_pkg;

    localparam int LENGTH_BITS = 32;

    localparam int TYPE_W = 6;
    localparam int LEN_W  = 32;

    // new format first length byte thresholds
    localparam logic [7:0] LEN_TWO_BYTE_MIN = 8'd192;
    localparam logic [7:0] LEN_PARTIAL_MIN  = 8'd224;
    localparam logic [7:0] LEN_FIVE_BYTE    = 8'd255;

    // old format length types
    localparam logic [1:0] OLD_LEN_ONE  = 2'd0;
    localparam logic [1:0] OLD_LEN_TWO  = 2'd1;
    localparam logic [1:0] OLD_LEN_FOUR = 2'd2;

    // length bytes still to come, plus a code for the second byte of the two-byte form
    localparam logic [2:0] LEFT_ONE    = 3'd1;
    localparam logic [2:0] LEFT_TWO    = 3'd2;
    localparam logic [2:0] LEFT_FOUR   = 3'd4;
    localparam logic [2:0] LEFT_SECOND = 3'd5;

    typedef enum logic [2:0] {
        ST_BODY    = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_STOP    = 3'd2,
        ST_FORMAT  = 3'd3,
        ST_TRUNC   = 3'd4,
        ST_NOMATCH = 3'd5
    } t_status;

    typedef struct packed {
        logic       eos;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        t_status             status;
        logic [TYPE_W-1:0]   packet_type;
        logic [7:0]          body_byte;
        logic                body_last;
        logic [LEN_W-1:0]    packet_length;
    } t_result;

endpackage

[src/opf_parser.sv]
module opf_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  opf_pkg::t_item            i_item,
    input  logic [opf_pkg::TYPE_W-1:0] i_want_type,
    input  logic [opf_pkg::TYPE_W-1:0] i_stop_type,
    output logic                      o_res_valid,
    output opf_pkg::t_result          o_res
);

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_LENGTH  = 5'b00010,
        PH_BODY    = 5'b00100,
        PH_SKIP    = 5'b01000,
        PH_DISCARD = 5'b10000
    } t_phase;

    t_phase                         r_phase, n_phase;
    logic [opf_pkg::TYPE_W-1:0]     r_type, n_type;
    logic [opf_pkg::LEN_W-1:0]      r_acc, n_acc;
    logic [2:0]                     r_left, n_left;
    logic [opf_pkg::LEN_W-1:0]      r_body, n_body;
    logic                           r_nff, n_nff;

    logic [7:0]                     b;
    logic                           done;
    logic [opf_pkg::LEN_W-1:0]      done_len;
    logic [opf_pkg::LEN_W-1:0]      acc_shift;
    logic [opf_pkg::LEN_W-1:0]      two_byte_len;

    assign b            = i_item.data_byte;
    assign acc_shift    = {r_acc[opf_pkg::LEN_W-9:0], b};
    assign two_byte_len = ((r_acc - opf_pkg::LEN_W'(opf_pkg::LEN_TWO_BYTE_MIN)) << 8)
                          + opf_pkg::LEN_W'(b) + opf_pkg::LEN_W'(opf_pkg::LEN_TWO_BYTE_MIN);

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_acc       = r_acc;
        n_left      = r_left;
        n_body      = r_body;
        n_nff       = r_nff;
        done        = 1'b0;
        done_len    = '0;
        o_res_valid = 1'b0;
        o_res       = '{status: opf_pkg::ST_BODY, packet_type: '0, body_byte: '0,
                        body_last: 1'b0, packet_length: '0};

        if (i_item.eos) begin
            if (r_phase == PH_HEADER) begin
                o_res_valid   = 1'b1;
                o_res.status  = opf_pkg::ST_NOMATCH;
            end else if (r_phase == PH_LENGTH || r_phase == PH_BODY || r_phase == PH_SKIP) begin
                o_res_valid         = 1'b1;
                o_res.status        = opf_pkg::ST_TRUNC;
                o_res.packet_type   = r_type;
                o_res.packet_length = r_acc;
            end
            n_phase = PH_HEADER;
            n_type  = '0;
            n_acc   = '0;
            n_left  = '0;
            n_body  = '0;
            n_nff   = 1'b0;
        end else begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (!b[7]) begin
                        o_res_valid  = 1'b1;
                        o_res.status = opf_pkg::ST_FORMAT;
                        n_phase      = PH_DISCARD;
                    end else begin
                        n_acc   = '0;
                        n_phase = PH_LENGTH;
                        if (b[6]) begin
                            n_type = b[5:0];
                            n_nff  = 1'b1;
                            n_left = opf_pkg::LEFT_ONE;
                        end else begin
                            n_type = {2'b00, b[5:2]};
                            n_nff  = 1'b0;
                            case (b[1:0])
                                opf_pkg::OLD_LEN_ONE:  n_left = opf_pkg::LEFT_ONE;
                                opf_pkg::OLD_LEN_TWO:  n_left = opf_pkg::LEFT_TWO;
                                opf_pkg::OLD_LEN_FOUR: n_left = opf_pkg::LEFT_FOUR;
                                default: begin
                                    // indeterminate length
                                    o_res_valid       = 1'b1;
                                    o_res.status      = opf_pkg::ST_FORMAT;
                                    o_res.packet_type = {2'b00, b[5:2]};
                                    n_phase           = PH_DISCARD;
                                end
                            endcase
                        end
                    end
                end
                PH_LENGTH: begin
                    if (r_nff) begin
                        n_nff = 1'b0;
                        if (b == opf_pkg::LEN_FIVE_BYTE) begin
                            n_left = opf_pkg::LEFT_FOUR;
                        end else if (b >= opf_pkg::LEN_PARTIAL_MIN) begin
                            // partial length
                            o_res_valid       = 1'b1;
                            o_res.status      = opf_pkg::ST_FORMAT;
                            o_res.packet_type = r_type;
                            n_phase           = PH_DISCARD;
                        end else if (b >= opf_pkg::LEN_TWO_BYTE_MIN) begin
                            n_acc  = opf_pkg::LEN_W'(b);
                            n_left = opf_pkg::LEFT_SECOND;
                        end else begin
                            done     = 1'b1;
                            done_len = opf_pkg::LEN_W'(b);
                        end
                    end else if (r_left == opf_pkg::LEFT_SECOND) begin
                        done     = 1'b1;
                        done_len = two_byte_len;
                    end else begin
                        n_acc  = acc_shift;
                        n_left = r_left - 3'd1;
                        if (r_left == opf_pkg::LEFT_ONE) begin
                            done     = 1'b1;
                            done_len = acc_shift;
                        end
                    end
                end
                PH_BODY: begin
                    o_res_valid         = 1'b1;
                    o_res.status        = opf_pkg::ST_BODY;
                    o_res.packet_type   = r_type;
                    o_res.body_byte     = b;
                    o_res.body_last     = (r_body == opf_pkg::LEN_W'(1));
                    o_res.packet_length = r_acc;
                    n_body              = r_body - opf_pkg::LEN_W'(1);
                    if (r_body == opf_pkg::LEN_W'(1)) begin
                        n_phase = PH_DISCARD;
                    end
                end
                PH_SKIP: begin
                    n_body = r_body - opf_pkg::LEN_W'(1);
                    if (r_body == opf_pkg::LEN_W'(1)) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_DISCARD: begin
                    n_phase = PH_DISCARD;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase

            if (done) begin
                if ((done_len >> opf_pkg::LENGTH_BITS) != '0) begin
                    o_res_valid         = 1'b1;
                    o_res.status        = opf_pkg::ST_FORMAT;
                    o_res.packet_type   = r_type;
                    o_res.packet_length = done_len;
                    n_phase             = PH_DISCARD;
                end else begin
                    n_acc  = done_len;
                    n_body = done_len;
                    n_left = '0;
                    n_nff  = 1'b0;
                    if (r_type == i_want_type) begin
                        if (done_len == '0) begin
                            o_res_valid       = 1'b1;
                            o_res.status      = opf_pkg::ST_EMPTY;
                            o_res.packet_type = r_type;
                            n_phase           = PH_DISCARD;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end else if (r_type == i_stop_type) begin
                        o_res_valid         = 1'b1;
                        o_res.status        = opf_pkg::ST_STOP;
                        o_res.packet_type   = r_type;
                        o_res.packet_length = done_len;
                        n_phase             = PH_DISCARD;
                    end else begin
                        n_phase = (done_len == '0) ? PH_HEADER : PH_SKIP;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_type  <= '0;
            r_acc   <= '0;
            r_left  <= '0;
            r_body  <= '0;
            r_nff   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_body  <= n_body;
            r_nff   <= n_nff;
        end
    end

endmodule

[src/openpgp_packet_filter.sv]
// Byte-stream filter for OpenPGP packets. Bytes arrive one per request on the
// slave stream (tuser set marks end of stream and rearms the block); headers in
// either format are decoded, packets of other tags are skipped, the body of a
// packet tagged want_type comes out one byte per request with tlast on the final
// byte, and stop, an empty wanted packet, format error, truncation or no match
// are reported as a single status request, after which bytes are dropped until
// end of stream. The block takes one byte per clock except when stalled; a result
// reaches the master stream through the input register and the result register
// around the packet parser, and a held result stalls the input only while it
// waits together with the next result.
// want_type sits at address 0 and stop_type at address 4; write them only while
// the stream is idle.
module openpgp_packet_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // end_of_stream

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // packet_type, body_byte, packet_length, zero pad
    output logic        m_axis_tlast,   // body_last
    output logic [2:0]  m_axis_tuser    // status
);

    logic [opf_pkg::TYPE_W-1:0] r_want_type;
    logic [opf_pkg::TYPE_W-1:0] r_stop_type;

    logic                       r_in_valid;
    opf_pkg::t_item             r_in;
    logic                       r_out_valid;
    opf_pkg::t_result           r_out;

    logic                       res_valid;
    opf_pkg::t_result           res;
    logic                       out_free;
    logic                       proc;
    logic                       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = paddr[2] ? {26'd0, r_stop_type} : {26'd0, r_want_type};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_want_type <= 6'd5;
            r_stop_type <= 6'd6;
        end else if (cfg_write) begin
            if (paddr[2]) begin
                r_stop_type <= pwdata[opf_pkg::TYPE_W-1:0];
            end else begin
                r_want_type <= pwdata[opf_pkg::TYPE_W-1:0];
            end
        end
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && (!res_valid || out_free);
    assign s_axis_tready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.data_byte <= s_axis_tdata;
            r_in.eos       <= s_axis_tuser;
        end
    end

    opf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (proc),
        .i_item      (r_in),
        .i_want_type (r_want_type),
        .i_stop_type (r_stop_type),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.packet_length, r_out.body_byte, r_out.packet_type};
    assign m_axis_tlast  = r_out.body_last;
    assign m_axis_tuser  = r_out.status;

endmodule
